### hdl/assert_macros.svh
// Assertion macros used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ESC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ESC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/esc_pkg.sv
// Types, constants and helper functions for the epoch to calendar converter.
`default_nettype none
package esc_pkg;

	localparam int DVD_W  = 33;
	localparam int REM_W  = 17;
	localparam int BIAS_W = 18;
	localparam int DAYN_W = 16;

	localparam logic [1:0] DSEL_DAY  = 2'd0;
	localparam logic [1:0] DSEL_HOUR = 2'd1;
	localparam logic [1:0] DSEL_MIN  = 2'd2;

	localparam logic [REM_W-1:0] SECS_DAY  = 17'd86400;
	localparam logic [REM_W-1:0] SECS_HOUR = 17'd3600;
	localparam logic [REM_W-1:0] SECS_MIN  = 17'd60;

	localparam logic signed [4:0] ZONE_RESET = 5'sd3;
	localparam logic [DAYN_W-1:0] DAY_BIAS   = 16'd364;

	localparam logic [11:0] YEAR_START = 12'd1969;
	localparam logic [6:0]  C100_START = 7'd69;
	localparam logic [8:0]  C400_START = 9'd369;
	localparam logic [6:0]  C100_LAST  = 7'd99;
	localparam logic [8:0]  C400_LAST  = 9'd399;
	localparam logic [3:0]  MONTH_DEC  = 4'd11;

	typedef struct packed {
		logic       load;
		logic       add_step;
		logic       div_step;
		logic [1:0] dsel;
		logic       ld_sod;
		logic       ld_min;
	} arith_ctl_t;

	typedef struct packed {
		logic        done;
		logic [11:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
	} walk_stat_t;

	function automatic logic [BIAS_W-1:0] zone_bias(input logic signed [4:0] z);
		logic signed [18:0] p;
		p = 19'(z) * 19'sd3600 + 19'sd86400;
		return p[BIAS_W-1:0];
	endfunction

	function automatic logic [REM_W-1:0] divisor(input logic [1:0] sel);
		logic [REM_W-1:0] d;
		unique case (sel)
			DSEL_DAY:  d = SECS_DAY;
			DSEL_HOUR: d = SECS_HOUR;
			DSEL_MIN:  d = SECS_MIN;
			default:   d = SECS_MIN;
		endcase
		return d;
	endfunction

	function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
		logic [4:0] len;
		unique case (m)
			4'd1:                      len = leap ? 5'd29 : 5'd28;
			4'd3, 4'd5, 4'd8, 4'd10:   len = 5'd30;
			default:                   len = 5'd31;
		endcase
		return len;
	endfunction

endpackage
`default_nettype wire

### hdl/esc_arith.sv
// Bit-serial adder and restoring divider sharing one shift register.
`default_nettype none
module esc_arith (
	input  wire logic                      clk,
	input  wire esc_pkg::arith_ctl_t       ctl,
	input  wire logic [31:0]               epoch_in,
	input  wire logic [esc_pkg::BIAS_W-1:0] bias_in,
	output logic [esc_pkg::DVD_W-1:0]      dvd,
	output logic [esc_pkg::REM_W-1:0]      rem
);
	import esc_pkg::*;

	logic [DVD_W-1:0]  dvd_q;
	logic [REM_W-1:0]  rem_q;
	logic [BIAS_W-1:0] addend_q;
	logic              carry_q;
	logic              sum_bit;
	logic              carry_nx;
	logic [REM_W:0]    trial;
	logic [REM_W:0]    diff;
	logic              ge;

	assign sum_bit  = dvd_q[0] ^ addend_q[0] ^ carry_q;
	assign carry_nx = (dvd_q[0] & addend_q[0]) | (carry_q & (dvd_q[0] ^ addend_q[0]));
	assign trial    = {rem_q, dvd_q[DVD_W-1]};
	assign diff     = trial - {1'b0, divisor(ctl.dsel)};
	assign ge       = (trial >= {1'b0, divisor(ctl.dsel)});

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			dvd_q    <= {1'b0, epoch_in};
			addend_q <= bias_in;
			carry_q  <= 1'b0;
			rem_q    <= '0;
		end else if (ctl.add_step) begin
			dvd_q    <= {sum_bit, dvd_q[DVD_W-1:1]};
			addend_q <= {1'b0, addend_q[BIAS_W-1:1]};
			carry_q  <= carry_nx;
		end else if (ctl.div_step) begin
			dvd_q <= {dvd_q[DVD_W-2:0], ge};
			rem_q <= ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
		end else if (ctl.ld_sod) begin
			dvd_q <= {rem_q, 16'd0};
			rem_q <= '0;
		end else if (ctl.ld_min) begin
			dvd_q <= {rem_q[11:0], 21'd0};
			rem_q <= '0;
		end
	end

	assign dvd = dvd_q;
	assign rem = rem_q;
endmodule
`default_nettype wire

### hdl/esc_walk.sv
// Year and month walk that turns a day count into a calendar date.
`default_nettype none
module esc_walk (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic [esc_pkg::DAYN_W-1:0] n_in,
	output esc_pkg::walk_stat_t             stat
);
	import esc_pkg::*;

	localparam logic [1:0] W_IDLE  = 2'd0;
	localparam logic [1:0] W_YEAR  = 2'd1;
	localparam logic [1:0] W_MONTH = 2'd2;

	logic [1:0]        wst_q;
	logic              done_q;
	logic [DAYN_W-1:0] n_q;
	logic [11:0]       year_q;
	logic [6:0]        c100_q;
	logic [8:0]        c400_q;
	logic [3:0]        mon_q;
	logic              leap;
	logic [8:0]        ylen;
	logic [4:0]        mlen;

	assign leap = (c400_q == '0) || ((c100_q != '0) && (year_q[1:0] == 2'd0));
	assign ylen = leap ? 9'd366 : 9'd365;
	assign mlen = month_len(mon_q, leap);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wst_q  <= W_IDLE;
			done_q <= 1'b0;
		end else if (start) begin
			wst_q  <= W_YEAR;
			done_q <= 1'b0;
		end else begin
			unique case (wst_q)
				W_YEAR: begin
					if (n_q < {7'd0, ylen}) begin
						wst_q <= W_MONTH;
					end
				end
				W_MONTH: begin
					if (!((mon_q < MONTH_DEC) && (n_q >= {11'd0, mlen}))) begin
						wst_q  <= W_IDLE;
						done_q <= 1'b1;
					end
				end
				default: begin
					wst_q <= W_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q    <= n_in;
			year_q <= YEAR_START;
			c100_q <= C100_START;
			c400_q <= C400_START;
			mon_q  <= '0;
		end else if (wst_q == W_YEAR && n_q >= {7'd0, ylen}) begin
			n_q    <= n_q - {7'd0, ylen};
			year_q <= year_q + 12'd1;
			c100_q <= (c100_q == C100_LAST) ? '0 : c100_q + 7'd1;
			c400_q <= (c400_q == C400_LAST) ? '0 : c400_q + 9'd1;
		end else if (wst_q == W_MONTH && mon_q < MONTH_DEC && n_q >= {11'd0, mlen}) begin
			n_q   <= n_q - {11'd0, mlen};
			mon_q <= mon_q + 4'd1;
		end
	end

	assign stat.done  = done_q;
	assign stat.year  = year_q;
	assign stat.month = mon_q + 4'd1;
	assign stat.day   = n_q[4:0] + 5'd1;
endmodule
`default_nettype wire

### hdl/epoch_seconds_to_calendar.sv
// Top level of the epoch seconds to local calendar date and time converter.
// Usage:
//   Command channel: drive epoch_seconds and pulse start while busy is low; the word
//   is taken at that clock edge and busy rises on the next cycle.
//   Result channel: done is high for exactly one cycle with year, month, day, hour,
//   minute and second valid; they hold until the next result. The receiver cannot
//   stall, so it must take the word in that cycle.
//   Configuration channel: cfg_valid with zone_offset_hours writes the zone offset
//   in hours; cfg_ready is always high. Write it only while busy is low.
//   Sequence: a bit-serial add and a bit-serial divide by the seconds of a day come
//   first, then the year and month walk runs at one year or one month per cycle
//   alongside the split of the time of day.
//   Throughput: one conversion at a time; a new start is taken in the cycle of done.
//   Reset: arst_n clears the control state and sets the zone offset to +3 hours.
`default_nettype none
module epoch_seconds_to_calendar (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [31:0] epoch_seconds,
	output logic             done,
	output logic [11:0]      year,
	output logic [3:0]       month,
	output logic [4:0]       day,
	output logic [4:0]       hour,
	output logic [5:0]       minute,
	output logic [5:0]       second,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [4:0]  zone_offset_hours
);
	import esc_pkg::*;

	localparam logic [2:0] S_IDLE     = 3'd0;
	localparam logic [2:0] S_ADD      = 3'd1;
	localparam logic [2:0] S_DIV_DAY  = 3'd2;
	localparam logic [2:0] S_LD_HOUR  = 3'd3;
	localparam logic [2:0] S_DIV_HOUR = 3'd4;
	localparam logic [2:0] S_LD_MIN   = 3'd5;
	localparam logic [2:0] S_DIV_MIN  = 3'd6;
	localparam logic [2:0] S_WAIT     = 3'd7;

	localparam logic [5:0] LAST_ADD  = 6'd32;
	localparam logic [5:0] LAST_DAY  = 6'd32;
	localparam logic [5:0] LAST_HOUR = 6'd16;
	localparam logic [5:0] LAST_MIN  = 6'd11;

	logic [2:0]         state_q;
	logic [2:0]         state_nx;
	logic [5:0]         cnt_q;
	logic               cnt_clr;
	logic signed [4:0]  zone_q;
	logic [4:0]         hour_q;
	logic               done_q;
	logic [11:0]        year_q;
	logic [3:0]         month_q;
	logic [4:0]         day_q;
	logic [4:0]         hr_out_q;
	logic [5:0]         min_q;
	logic [5:0]         sec_q;
	logic               accept;
	logic               walk_start;
	arith_ctl_t         ctl;
	walk_stat_t         wstat;
	logic [DVD_W-1:0]   dvd;
	logic [REM_W-1:0]   rem;
	logic [DAYN_W-1:0]  n_in;

	assign accept     = start && (state_q == S_IDLE);
	assign walk_start = (state_q == S_LD_HOUR);
	assign n_in       = dvd[DAYN_W-1:0] + DAY_BIAS;

	always_comb begin
		ctl      = '0;
		state_nx = state_q;
		cnt_clr  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					ctl.load = 1'b1;
					state_nx = S_ADD;
					cnt_clr  = 1'b1;
				end
			end
			S_ADD: begin
				ctl.add_step = 1'b1;
				if (cnt_q == LAST_ADD) begin
					state_nx = S_DIV_DAY;
					cnt_clr  = 1'b1;
				end
			end
			S_DIV_DAY: begin
				ctl.div_step = 1'b1;
				ctl.dsel     = DSEL_DAY;
				if (cnt_q == LAST_DAY) begin
					state_nx = S_LD_HOUR;
				end
			end
			S_LD_HOUR: begin
				ctl.ld_sod = 1'b1;
				state_nx   = S_DIV_HOUR;
				cnt_clr    = 1'b1;
			end
			S_DIV_HOUR: begin
				ctl.div_step = 1'b1;
				ctl.dsel     = DSEL_HOUR;
				if (cnt_q == LAST_HOUR) begin
					state_nx = S_LD_MIN;
				end
			end
			S_LD_MIN: begin
				ctl.ld_min = 1'b1;
				state_nx   = S_DIV_MIN;
				cnt_clr    = 1'b1;
			end
			S_DIV_MIN: begin
				ctl.div_step = 1'b1;
				ctl.dsel     = DSEL_MIN;
				if (cnt_q == LAST_MIN) begin
					state_nx = S_WAIT;
				end
			end
			S_WAIT: begin
				if (wstat.done) begin
					state_nx = S_IDLE;
				end
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
			zone_q  <= ZONE_RESET;
		end else begin
			state_q <= state_nx;
			cnt_q   <= cnt_clr ? '0 : cnt_q + 6'd1;
			done_q  <= (state_q == S_WAIT) && wstat.done;
			if (cfg_valid) begin
				zone_q <= zone_offset_hours;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_LD_MIN) begin
			hour_q <= dvd[4:0];
		end
		if (state_q == S_WAIT && wstat.done) begin
			year_q   <= wstat.year;
			month_q  <= wstat.month;
			day_q    <= wstat.day;
			hr_out_q <= hour_q;
			min_q    <= dvd[5:0];
			sec_q    <= rem[5:0];
		end
	end

	esc_arith u_arith (
		.clk      (clk),
		.ctl      (ctl),
		.epoch_in (epoch_seconds),
		.bias_in  (zone_bias(zone_q)),
		.dvd      (dvd),
		.rem      (rem)
	);

	esc_walk u_walk (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (walk_start),
		.n_in   (n_in),
		.stat   (wstat)
	);

	assign busy      = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign done      = done_q;
	assign year      = year_q;
	assign month     = month_q;
	assign day       = day_q;
	assign hour      = hr_out_q;
	assign minute    = min_q;
	assign second    = sec_q;
endmodule
`default_nettype wire

### hdl/esc_checker.sv
// Port-level checker for the converter and its bind to the top level.
`default_nettype none
`include "assert_macros.svh"
module esc_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        start,
	input wire logic        busy,
	input wire logic        done,
	input wire logic [3:0]  month,
	input wire logic [4:0]  day,
	input wire logic [4:0]  hour,
	input wire logic [5:0]  minute,
	input wire logic [5:0]  second
);
	`ESC_ASSERT_NEXT(a_start_busy, clk, arst_n, start && !busy, busy && !done, "accepted word did not raise busy")
	`ESC_ASSERT_NOW(a_done_idle, clk, arst_n, done, !busy, "result shown while still busy")
	`ESC_ASSERT_NEXT(a_done_pulse, clk, arst_n, done, !done, "result strobe longer than one cycle")
	`ESC_ASSERT_NOW(a_date_range, clk, arst_n, done, month >= 4'd1 && month <= 4'd12 && day >= 5'd1, "date field out of range")
	`ESC_ASSERT_NOW(a_time_range, clk, arst_n, done, hour <= 5'd23 && minute <= 6'd59 && second <= 6'd59, "time field out of range")
endmodule

bind epoch_seconds_to_calendar esc_checker u_esc_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.month  (month),
	.day    (day),
	.hour   (hour),
	.minute (minute),
	.second (second)
);
`default_nettype wire
